// ===== design/gsi_pkg.sv =====
// Shared types and constants of the gain schedule interpolator.
// Holds the sequencer state type, point layout, opcode and gain selector codes.
// Depends on nothing.
package gsi_pkg;

  // Opcode of an input request.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Fraction bits of the Q16.16 format and of the interpolation weight.
  localparam int FRAC_BITS = 16;

  // The weight runs over 0..65536, so the serial divide yields 17 quotient bits.
  localparam logic [4:0] DIV_STEPS = 5'd17;

  // Gain selector of the shared multiplier.
  localparam logic [1:0] GAIN_P = 2'd0;
  localparam logic [1:0] GAIN_I = 2'd1;
  localparam logic [1:0] GAIN_D = 2'd2;

  // One stored gain point, 128 bits.
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] gp;
    logic signed [31:0] gi;
    logic signed [31:0] gd;
  } point_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_RD_LAST,
    ST_CHK_LAST,
    ST_RD_SCAN,
    ST_CHK_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_FINISH
  } state_t;

endpackage

// ===== design/gsi_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module gsi_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/gain_schedule_interpolator.sv =====
// Top level of the gain schedule interpolator: point table, scan sequencer,
// serial divider and the shared multiplier for the three gains.
// Depends on gsi_pkg and gsi_ram.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+--------------------------------------------
//  item     | item_valid / item_stall    | opcode, point_index, position, gain_p/i/d
//  result   | result_valid / result_stall| gains_valid, sched_p, sched_i, sched_d
//  cfg      | cfg_valid / cfg_ready      | cfg_data (point_count)
//
// A write request gives no result. A query with fewer than two points goes straight
// to the finishing step; one at or beyond an end point finishes after the check of
// that end point. An interior query scans the table upward from the second slot:
// each scan step is one read of the table RAM and one compare, then a 17-step
// restoring divide and one multiply and add per gain.
// Reset (rst, synchronous) clears point_count, the sequencer and the result valid.
// The table RAM is not cleared. A finished result waits in the output register
// while result_stall is high, and the block keeps taking requests meanwhile; the
// next query to finish holds in its finishing step until that register frees up.
module gain_schedule_interpolator #(
  parameter int MAX_POINTS = 16
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                item_valid,
  output logic                item_stall,
  input  logic                opcode,
  input  logic [3:0]          point_index,
  input  logic signed [31:0]  position,
  input  logic signed [31:0]  gain_p,
  input  logic signed [31:0]  gain_i,
  input  logic signed [31:0]  gain_d,

  output logic                result_valid,
  input  logic                result_stall,
  output logic                gains_valid,
  output logic signed [31:0]  sched_p,
  output logic signed [31:0]  sched_i,
  output logic signed [31:0]  sched_d,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);

  // Address width of the table and width of a point count up to MAX_POINTS.
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  gsi_pkg::state_t state, state_next;

  logic [4:0]          point_count;
  logic [CW-1:0]       n_eff;
  logic [CW-1:0]       n_reg;
  logic signed [31:0]  qpos;
  logic [AW-1:0]       k;

  // Lower and upper points of the interval being interpolated.
  gsi_pkg::point_t     lo;
  gsi_pkg::point_t     hi;

  // Serial divider state.
  logic [32:0]         span_r;
  logic [33:0]         rem;
  logic [33:0]         rem_shift;
  logic                rem_ge;
  logic [4:0]          div_cnt;
  logic [16:0]         quo;

  // Shared multiplier.
  logic [1:0]          g_sel;
  logic signed [32:0]  diff;
  logic signed [31:0]  lo_gain;
  logic signed [50:0]  prod;
  logic [31:0]         mix;

  // Result waiting for the output register.
  logic                res_ok;
  logic signed [31:0]  res_p;
  logic signed [31:0]  res_i;
  logic signed [31:0]  res_d;

  // Table RAM.
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [127:0]        ram_rdata;
  gsi_pkg::point_t     rd_pt;
  gsi_pkg::point_t     wr_pt;

  logic                item_take;
  logic                query_take;
  logic                out_load;
  logic                found;
  logic                below_first;
  logic                above_last;
  logic signed [32:0]  span_calc;
  logic signed [32:0]  num_calc;

  assign cfg_ready  = 1'b1;
  assign item_take  = item_valid && !item_stall;
  assign query_take = item_take && (opcode == gsi_pkg::OP_QUERY);
  assign out_load   = (state == gsi_pkg::ST_FINISH) && (!result_valid || !result_stall);

  // A count above the table depth saturates to the depth.
  assign n_eff = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);

  assign rd_pt = gsi_pkg::point_t'(ram_rdata);
  assign wr_pt = '{pos: position, gp: gain_p, gi: gain_i, gd: gain_d};

  assign below_first = (qpos <= rd_pt.pos);
  assign above_last  = (qpos >= rd_pt.pos);
  assign found       = (qpos <= rd_pt.pos);

  // Span and offset against the lower point; both are positive for a found interval.
  assign span_calc = $signed({rd_pt.pos[31], rd_pt.pos}) - $signed({lo.pos[31], lo.pos});
  assign num_calc  = $signed({qpos[31], qpos}) - $signed({lo.pos[31], lo.pos});

  // One restoring divide step; the first step has no shift because the offset
  // never exceeds the span.
  assign rem_shift = (div_cnt == 5'd0) ? rem : {rem[32:0], 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, span_r});

  always_comb begin
    case (g_sel)
      gsi_pkg::GAIN_P: begin
        diff    = $signed({hi.gp[31], hi.gp}) - $signed({lo.gp[31], lo.gp});
        lo_gain = lo.gp;
      end
      gsi_pkg::GAIN_I: begin
        diff    = $signed({hi.gi[31], hi.gi}) - $signed({lo.gi[31], lo.gi});
        lo_gain = lo.gi;
      end
      default: begin
        diff    = $signed({hi.gd[31], hi.gd}) - $signed({lo.gd[31], lo.gd});
        lo_gain = lo.gd;
      end
    endcase
  end

  // The interpolated gain is in range, so its low 32 bits are the answer; the
  // product shifted right by the fraction bits is the floor of the weighted step.
  assign mix = lo_gain + prod[gsi_pkg::FRAC_BITS +: 32];

  gsi_ram #(
    .WIDTH (128),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(point_index)),
    .wdata (wr_pt),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gsi_pkg::ST_IDLE: begin
        if (query_take) begin
          state_next = (n_eff < CW'(2)) ? gsi_pkg::ST_FINISH : gsi_pkg::ST_RD_FIRST;
        end
      end
      gsi_pkg::ST_RD_FIRST:  state_next = gsi_pkg::ST_CHK_FIRST;
      gsi_pkg::ST_CHK_FIRST: begin
        state_next = below_first ? gsi_pkg::ST_FINISH : gsi_pkg::ST_RD_LAST;
      end
      gsi_pkg::ST_RD_LAST:   state_next = gsi_pkg::ST_CHK_LAST;
      gsi_pkg::ST_CHK_LAST: begin
        state_next = above_last ? gsi_pkg::ST_FINISH : gsi_pkg::ST_RD_SCAN;
      end
      gsi_pkg::ST_RD_SCAN:   state_next = gsi_pkg::ST_CHK_SCAN;
      gsi_pkg::ST_CHK_SCAN: begin
        state_next = found ? gsi_pkg::ST_DIV : gsi_pkg::ST_RD_SCAN;
      end
      gsi_pkg::ST_DIV: begin
        if (div_cnt == gsi_pkg::DIV_STEPS - 5'd1) begin
          state_next = gsi_pkg::ST_MUL;
        end
      end
      gsi_pkg::ST_MUL:       state_next = gsi_pkg::ST_ADD;
      gsi_pkg::ST_ADD: begin
        state_next = (g_sel == gsi_pkg::GAIN_D) ? gsi_pkg::ST_FINISH : gsi_pkg::ST_MUL;
      end
      gsi_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = gsi_pkg::ST_IDLE;
        end
      end
      default:               state_next = gsi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    item_stall = (state != gsi_pkg::ST_IDLE);
    ram_we     = item_take && (opcode == gsi_pkg::OP_WRITE) &&
                 (32'(point_index) < MAX_POINTS);
    case (state)
      gsi_pkg::ST_RD_LAST: ram_raddr = AW'(n_reg - CW'(1));
      gsi_pkg::ST_RD_SCAN: ram_raddr = k;
      default:             ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gsi_pkg::ST_IDLE;
      point_count  <= 5'd0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        point_count <= cfg_data;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (query_take) begin
      qpos   <= position;
      n_reg  <= n_eff;
      res_ok <= 1'b0;
      res_p  <= '0;
      res_i  <= '0;
      res_d  <= '0;
    end
    case (state)
      gsi_pkg::ST_CHK_FIRST: begin
        lo <= rd_pt;
        if (below_first) begin
          res_ok <= 1'b1;
          res_p  <= rd_pt.gp;
          res_i  <= rd_pt.gi;
          res_d  <= rd_pt.gd;
        end
      end
      gsi_pkg::ST_CHK_LAST: begin
        k <= AW'(1);
        if (above_last) begin
          res_ok <= 1'b1;
          res_p  <= rd_pt.gp;
          res_i  <= rd_pt.gi;
          res_d  <= rd_pt.gd;
        end
      end
      gsi_pkg::ST_CHK_SCAN: begin
        if (found) begin
          hi      <= rd_pt;
          span_r  <= span_calc[32:0];
          rem     <= {1'b0, num_calc[32:0]};
          div_cnt <= 5'd0;
          quo     <= '0;
        end else begin
          lo <= rd_pt;
          k  <= k + AW'(1);
        end
      end
      gsi_pkg::ST_DIV: begin
        rem     <= rem_ge ? (rem_shift - {1'b0, span_r}) : rem_shift;
        quo     <= {quo[15:0], rem_ge};
        div_cnt <= div_cnt + 5'd1;
        g_sel   <= gsi_pkg::GAIN_P;
      end
      gsi_pkg::ST_MUL: begin
        prod <= $signed({1'b0, quo}) * diff;
      end
      gsi_pkg::ST_ADD: begin
        res_ok <= 1'b1;
        case (g_sel)
          gsi_pkg::GAIN_P: res_p <= mix;
          gsi_pkg::GAIN_I: res_i <= mix;
          default:         res_d <= mix;
        endcase
        g_sel <= g_sel + 2'd1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      gains_valid <= res_ok;
      sched_p     <= res_p;
      sched_i     <= res_i;
      sched_d     <= res_d;
    end
  end

`ifndef SYNTHESIS
  // A new result only comes out of the finishing step.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == gsi_pkg::ST_FINISH))
    else $error("result valid rose outside the finishing step");

  // The divider remainder never exceeds the span.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == gsi_pkg::ST_DIV) |-> (span_r != 33'd0 && rem <= {1'b0, span_r}))
    else $error("divider remainder out of bound");

  // The scan stays between the second and the last point in use.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == gsi_pkg::ST_RD_SCAN) |-> (k != '0 && 32'(k) < 32'(n_reg)))
    else $error("scan index out of range");

  // A result that reports no gains carries zero gains.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !gains_valid) |-> (sched_p == 0 && sched_i == 0 && sched_d == 0))
    else $error("invalid result carries nonzero gains");
`endif

endmodule
